### rtl/core/hrp_pkg.sv
// ----------------------------------------------------------------------------
// hrp_pkg
// shared types and constants of the hex record parser
// ----------------------------------------------------------------------------
package hrp_pkg;

  localparam int unsigned QueueDepthDefault = 4;

  localparam logic [7:0] CharColon   = 8'h3a;
  localparam logic [7:0] CharZero    = 8'h30;
  localparam logic [7:0] CharNine    = 8'h39;
  localparam logic [7:0] CharUpperA  = 8'h41;
  localparam logic [7:0] CharUpperF  = 8'h46;
  localparam logic [7:0] AlphaOffset = 8'd55;
  localparam logic [7:0] TypeEof     = 8'h01;

  typedef enum logic [1:0] {
    TOK_HEX,
    TOK_COLON,
    TOK_OTHER
  } tok_kind_e;

  typedef struct packed {
    tok_kind_e  kind;
    logic [3:0] nibble;
  } token_t;

  typedef enum logic [2:0] {
    KIND_DATA    = 3'd0,
    KIND_OK      = 3'd1,
    KIND_EOF     = 3'd2,
    KIND_BADCHAR = 3'd3,
    KIND_BADSUM  = 3'd4
  } kind_e;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_HEADER,
    PH_DATA,
    PH_CHECK
  } phase_e;

  typedef enum logic [1:0] {
    HB_LENGTH   = 2'd0,
    HB_ADDR_HI  = 2'd1,
    HB_ADDR_LO  = 2'd2,
    HB_TYPE     = 2'd3
  } hdr_byte_e;

endpackage

### rtl/core/hrp_classify.sv
// ----------------------------------------------------------------------------
// hrp_classify
// front end: takes characters and turns them into hex, colon or other tokens
// ----------------------------------------------------------------------------
module hrp_classify (
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic [7:0]      character_i,
  input  logic            queue_full_i,
  output logic            push_o,
  output hrp_pkg::token_t token_o
);
  import hrp_pkg::*;

  assign in_ready_o = !queue_full_i;
  assign push_o     = in_valid_i && !queue_full_i;

  always_comb begin
    logic [7:0] diff;
    diff           = 8'd0;
    token_o.kind   = TOK_OTHER;
    token_o.nibble = 4'd0;
    if (character_i inside {[CharUpperA:CharUpperF]}) begin
      diff           = character_i - AlphaOffset;
      token_o.kind   = TOK_HEX;
      token_o.nibble = diff[3:0];
    end else if (character_i inside {[CharZero:CharNine]}) begin
      diff           = character_i - CharZero;
      token_o.kind   = TOK_HEX;
      token_o.nibble = diff[3:0];
    end else if (character_i == CharColon) begin
      token_o.kind   = TOK_COLON;
    end
  end

endmodule

### rtl/core/hrp_queue.sv
// ----------------------------------------------------------------------------
// hrp_queue
// short token fifo between the classifier and the record engine
// ----------------------------------------------------------------------------
module hrp_queue #(
  parameter int unsigned Depth = hrp_pkg::QueueDepthDefault
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  hrp_pkg::token_t token_i,
  output logic            full_o,
  output logic            valid_o,
  output hrp_pkg::token_t token_o,
  input  logic            pop_i
);
  import hrp_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(Depth);

  token_t          mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;

  assign full_o  = (count_q == CntFull);
  assign valid_o = (count_q != '0);
  assign token_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (push_i && !pop_i) begin
      count_d = count_q + CntW'(1);
    end else if (!push_i && pop_i) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= token_i;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o |-> !push_i)
    else $error("token queue written while full");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> valid_o)
    else $error("token queue read while empty");

endmodule

### rtl/core/hrp_record.sv
// ----------------------------------------------------------------------------
// hrp_record
// back end: record state machine, byte assembly, checksum and result register
// ----------------------------------------------------------------------------
module hrp_record (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             tok_valid_i,
  input  hrp_pkg::token_t  token_i,
  output logic             pop_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output hrp_pkg::kind_e   kind_o,
  output logic [15:0]      record_address_o,
  output logic [7:0]       byte_offset_o,
  output logic [7:0]       data_byte_o,
  output logic [7:0]       record_type_o,
  output logic [7:0]       record_length_o
);
  import hrp_pkg::*;

  phase_e      phase_q, phase_d;
  logic [1:0]  byte_idx_q, byte_idx_d;
  logic        pend_q, pend_d;
  logic [3:0]  hi_q, hi_d;
  logic [7:0]  sum_q, sum_d;
  logic [7:0]  len_q, len_d;
  logic [15:0] addr_q, addr_d;
  logic [7:0]  type_q, type_d;
  logic [7:0]  count_q, count_d;

  logic        out_valid_q;
  kind_e       kind_q;
  logic [15:0] res_addr_q;
  logic [7:0]  res_off_q, res_data_q, res_type_q, res_len_q;

  logic        take;
  logic        emit;
  kind_e       emit_kind;
  logic [7:0]  emit_data;
  logic [7:0]  byte_val;
  logic [7:0]  sum_next;

  // the result register frees up in the same cycle it is taken
  assign take     = tok_valid_i && (!out_valid_q || out_ready_i);
  assign pop_o    = take;
  assign byte_val = {hi_q, token_i.nibble};
  assign sum_next = sum_q + byte_val;

  // next state and record fields
  always_comb begin
    phase_d    = phase_q;
    byte_idx_d = byte_idx_q;
    pend_d     = pend_q;
    hi_d       = hi_q;
    sum_d      = sum_q;
    len_d      = len_q;
    addr_d     = addr_q;
    type_d     = type_q;
    count_d    = count_q;
    if (take) begin
      if (phase_q == PH_IDLE) begin
        if (token_i.kind == TOK_COLON) begin
          phase_d    = PH_HEADER;
          byte_idx_d = '0;
          pend_d     = 1'b0;
          hi_d       = '0;
          sum_d      = '0;
          len_d      = '0;
          addr_d     = '0;
          type_d     = '0;
          count_d    = '0;
        end
      end else if (token_i.kind != TOK_HEX) begin
        phase_d = PH_IDLE;
      end else if (!pend_q) begin
        hi_d   = token_i.nibble;
        pend_d = 1'b1;
      end else begin
        pend_d = 1'b0;
        sum_d  = sum_next;
        case (phase_q)
          PH_HEADER: begin
            case (hdr_byte_e'(byte_idx_q))
              HB_LENGTH:  len_d  = byte_val;
              HB_ADDR_HI: addr_d = {byte_val, addr_q[7:0]};
              HB_ADDR_LO: addr_d = {addr_q[15:8], byte_val};
              default:    type_d = byte_val;
            endcase
            if (hdr_byte_e'(byte_idx_q) == HB_TYPE) begin
              byte_idx_d = '0;
              count_d    = '0;
              phase_d    = (len_q == 8'd0) ? PH_CHECK : PH_DATA;
            end else begin
              byte_idx_d = byte_idx_q + 2'd1;
            end
          end
          PH_DATA: begin
            count_d = count_q + 8'd1;
            if (count_q + 8'd1 == len_q) begin
              phase_d = PH_CHECK;
            end
          end
          default: begin
            phase_d = PH_IDLE;
          end
        endcase
      end
    end
  end

  // result selection
  always_comb begin
    emit      = 1'b0;
    emit_kind = KIND_OK;
    emit_data = 8'd0;
    if (take && phase_q != PH_IDLE) begin
      if (token_i.kind != TOK_HEX) begin
        emit      = 1'b1;
        emit_kind = KIND_BADCHAR;
      end else if (pend_q) begin
        case (phase_q)
          PH_DATA: begin
            emit      = 1'b1;
            emit_kind = KIND_DATA;
            emit_data = byte_val;
          end
          PH_CHECK: begin
            emit = 1'b1;
            if (sum_next != 8'd0) begin
              emit_kind = KIND_BADSUM;
            end else if (type_q == TypeEof) begin
              emit_kind = KIND_EOF;
            end else begin
              emit_kind = KIND_OK;
            end
          end
          default: begin
            emit = 1'b0;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      byte_idx_q  <= '0;
      pend_q      <= 1'b0;
      hi_q        <= '0;
      sum_q       <= '0;
      len_q       <= '0;
      addr_q      <= '0;
      type_q      <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q    <= phase_d;
      byte_idx_q <= byte_idx_d;
      pend_q     <= pend_d;
      hi_q       <= hi_d;
      sum_q      <= sum_d;
      len_q      <= len_d;
      addr_q     <= addr_d;
      type_q     <= type_d;
      count_q    <= count_d;
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      kind_q     <= emit_kind;
      res_addr_q <= addr_q;
      res_off_q  <= count_q;
      res_data_q <= emit_data;
      res_type_q <= type_q;
      res_len_q  <= len_q;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign kind_o           = kind_q;
  assign record_address_o = res_addr_q;
  assign byte_offset_o    = res_off_q;
  assign data_byte_o      = res_data_q;
  assign record_type_o    = res_type_q;
  assign record_length_o  = res_len_q;

  a_data_offset_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && kind_q == KIND_DATA |-> res_off_q < res_len_q)
    else $error("data byte offset beyond record length");

  a_data_phase_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_DATA |-> byte_idx_q == 2'd0 && len_q != 8'd0 && count_q < len_q)
    else $error("data phase entered with bad header state");

  a_check_after_all_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_CHECK |-> count_q == len_q)
    else $error("checksum phase before all data bytes");

  a_no_result_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_ready_i |-> !take)
    else $error("token consumed while result register is stalled");

endmodule

### rtl/core/hex_record_parser.sv
// ----------------------------------------------------------------------------
// hex_record_parser
// intel hex record parser, one ascii character per request
// ----------------------------------------------------------------------------
// Characters enter on the in channel (in_valid_i / in_ready_o, character_i).
// A colon opens a record; upper-case hex digit pairs then give length,
// address (high byte first), type, data and checksum. Each data byte leaves
// as one request on the out channel; the checksum closes the record with an
// ok, end-of-file or bad-checksum status. A bad character inside a record
// reports an error and drops back to waiting for a colon.
// Throughput: one character per cycle, sustained while out_ready_i is high and
// QueueDepth is above one. A character's result, if it has one, passes through
// the token queue register and then the result register. The record engine,
// which sets the rate, updates once for each character it takes.
// Reset empties the token queue and puts the engine in wait for a colon.
// While a result waits with out_ready_i low, the result register holds, the
// engine stops and up to QueueDepth characters queue before in_ready_o falls.
// ----------------------------------------------------------------------------
module hex_record_parser #(
  parameter int unsigned QueueDepth = hrp_pkg::QueueDepthDefault
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  logic [7:0]     character_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output hrp_pkg::kind_e kind_o,
  output logic [15:0]    record_address_o,
  output logic [7:0]     byte_offset_o,
  output logic [7:0]     data_byte_o,
  output logic [7:0]     record_type_o,
  output logic [7:0]     record_length_o
);
  import hrp_pkg::*;

  logic   push;
  token_t push_tok;
  logic   q_full;
  logic   q_valid;
  token_t q_tok;
  logic   pop;

  hrp_classify u_classify (
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .character_i  (character_i),
    .queue_full_i (q_full),
    .push_o       (push),
    .token_o      (push_tok)
  );

  hrp_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .token_i (push_tok),
    .full_o  (q_full),
    .valid_o (q_valid),
    .token_o (q_tok),
    .pop_i   (pop)
  );

  hrp_record u_record (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .tok_valid_i      (q_valid),
    .token_i          (q_tok),
    .pop_o            (pop),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .kind_o           (kind_o),
    .record_address_o (record_address_o),
    .byte_offset_o    (byte_offset_o),
    .data_byte_o      (data_byte_o),
    .record_type_o    (record_type_o),
    .record_length_o  (record_length_o)
  );

endmodule
